/* design/d2f_pkg.sv */
// Package for the binary64 to binary32 saturating converter.
// Holds the format constants shared by the converter datapath and the top level.
package d2f_pkg;
  localparam int unsigned DblW = 64;
  localparam int unsigned FltW = 32;
  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [30:0] INF31 = 31'h7F80_0000;
  localparam logic [30:0] MAX31 = 31'h7F7F_FFFF;
  localparam logic [62:0] FLT_MAX_AS63 = 63'h47EF_FFFF_E000_0000;
endpackage

/* design/d2f_conv.sv */
// Combinational binary64 to binary32 conversion with round to nearest even.
// Depends on d2f_pkg for format constants.
module d2f_conv import d2f_pkg::*; (
  input  logic [DblW-1:0] dbl,
  output logic [FltW-1:0] flt
);
  logic        sgn;
  logic [10:0] ex;
  logic [51:0] frac;
  logic [52:0] mant;
  logic [5:0]  sh;
  logic [52:0] q;
  logic [52:0] rem;
  logic [53:0] half;
  logic [52:0] msk;
  logic [52:0] qr;
  logic [30:0] mag;

  always_comb begin
    sgn  = dbl[63];
    ex   = dbl[62:52];
    frac = dbl[51:0];
    mant = {1'b1, frac};
    // Normal results shift by 29; subnormal results by 926 - ex, capped at 54.
    if (ex >= 11'd897) begin
      sh = 6'd29;
    end else if (ex <= 11'd872) begin
      sh = 6'd54;
    end else begin
      sh = 6'(11'd926 - ex);
    end
    q    = mant >> sh;
    msk  = ~(53'h1F_FFFF_FFFF_FFFF << sh);
    rem  = mant & msk;
    // At the largest shift the half point lies above every mantissa, so it needs one more bit.
    half = 54'd1 << (sh - 6'd1);
    qr   = q + {52'd0, ({1'b0, rem} > half) || (({1'b0, rem} == half) && q[0])};
    if (ex >= 11'd897) begin
      // The rounding carry propagates into the exponent field.
      mag = 31'({20'd0, ex - 11'd896} << 23) - 31'h0080_0000 + 31'(qr);
    end else begin
      mag = 31'(qr);
    end
    if (ex == 11'h7FF) begin
      flt = (frac != 52'd0) ? QNAN32 : {sgn, INF31};
    end else if (ex == 11'd0) begin
      flt = {sgn, 30'd0, frac != 52'd0};
    end else if (dbl[62:0] > FLT_MAX_AS63) begin
      flt = {sgn, MAX31};
    end else begin
      flt = {sgn, mag};
    end
  end
endmodule

/* design/double_to_float_saturating.sv */
// Converts one binary64 bit pattern per cycle into a saturating binary32 pattern.
// Transfers enter an input register, are converted, and leave from a result
// register; either register moves whenever its downstream side is free.
// One item is taken every cycle while the output is not stalled. Depends on d2f_pkg
// and d2f_conv.
module double_to_float_saturating import d2f_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [DblW-1:0] in_double_bits,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [FltW-1:0] out_float_bits
);
  logic            a_vld_r;
  logic [DblW-1:0] a_dat_r;
  logic            o_vld_r;
  logic [FltW-1:0] o_dat_r;
  logic [FltW-1:0] conv;
  logic            o_take;
  logic            a_take;

  d2f_conv u_conv (.dbl(a_dat_r), .flt(conv));

  assign o_take   = !o_vld_r || !out_stall;
  assign a_take   = !a_vld_r || o_take;
  assign in_stall = !a_take;
  assign out_valid      = o_vld_r;
  assign out_float_bits = o_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (a_take) begin
        a_vld_r <= in_valid;
      end
      if (o_take) begin
        o_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && in_valid) begin
      a_dat_r <= in_double_bits;
    end
    if (o_take && a_vld_r) begin
      o_dat_r <= conv;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r && out_stall |=> o_vld_r && $stable(o_dat_r))
    else $error("result changed while stalled");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && o_take |=> o_vld_r)
    else $error("converted item lost");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_vld_r && o_vld_r && out_stall)
    else $error("input stalled without cause");
`endif
endmodule

/* dv/tb_double_to_float_saturating.sv */
// Testbench for the binary64 to binary32 saturating converter.
// Drives random and directed doubles, predicts each float and checks results in order.
// Depends on d2f_pkg and the double_to_float_saturating RTL.
module tb_double_to_float_saturating;
  import d2f_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [DblW-1:0] in_double_bits = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [FltW-1:0] out_float_bits;

  logic [31:0] expected_floats[$];
  int          error_count = 0;
  int          checked_count = 0;
  bit          quiet_phase = 1'b0;

  double_to_float_saturating DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_double_bits(in_double_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_float_bits(out_float_bits)
  );

  always #1 clk = ~clk;

  // Right shift with round to nearest, ties to even.
  function automatic logic [63:0] shift_round_even(logic [63:0] v, int sh);
    logic [63:0] q, rem, half;
    q = v >> sh;
    rem = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [31:0] convert_double(logic [63:0] x);
    logic [31:0] sgn;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [63:0] mant, q, r;
    int e, s;
    sgn = {x[63], 31'd0};
    ex = x[62:52];
    frac = x[51:0];
    if (ex == 11'h7FF) begin
      return (frac != 0) ? QNAN32 : (sgn | {1'b0, INF31});
    end
    if (ex == 11'd0) return (frac != 0) ? (sgn | 32'd1) : sgn;
    if (x[62:0] > FLT_MAX_AS63) return sgn | {1'b0, MAX31};
    e = int'(ex) - 1023;
    mant = {12'd1, frac};
    if (e >= -126) begin
      q = shift_round_even(mant, 29);
      r = (64'(e + 126) << 23) + q;
      return sgn | {1'b0, r[30:0]};
    end
    s = -e - 97;
    q = (s >= 55) ? 64'd0 : shift_round_even(mant, s);
    return sgn | {1'b0, q[30:0]};
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Sends one double; predicts at the transfer edge. Random sender gaps.
  // Valid stays high between back-to-back transfers and drops only for a gap.
  task automatic send_double(logic [63:0] d);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_double_bits <= d;
    do @(posedge clk); while (in_stall);
    expected_floats.push_back(convert_double(d));
  endtask

  // Receiver stall bursts.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_floats.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_float_bits));
      end else begin
        want = expected_floats.pop_front();
        checked_count++;
        if (out_float_bits !== want)
          report_mismatch($sformatf("float_bits %h, expected %h", out_float_bits, want));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_special_values();
    send_double(64'h0000_0000_0000_0000);
    send_double(64'h8000_0000_0000_0000);
    send_double(64'h7FF0_0000_0000_0000);
    send_double(64'hFFF0_0000_0000_0000);
    send_double(64'h7FF8_0000_0000_0000);
    send_double(64'hFFF0_0000_0000_0001);
    send_double(64'h7FFF_FFFF_FFFF_FFFF);
    send_double(64'h0000_0000_0000_0001);
    send_double(64'h800F_FFFF_FFFF_FFFF);
    send_double(64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_range_edges();
    send_double(64'h47EF_FFFF_E000_0000);
    send_double(64'h47EF_FFFF_E000_0001);
    send_double(64'hC7EF_FFFF_F000_0000);
    send_double(64'h7FEF_FFFF_FFFF_FFFF);
    send_double(64'h3810_0000_0000_0000);
    send_double(64'h3690_0000_0000_0000);
    send_double(64'h3690_0000_0000_0001);
    send_double(64'h3680_0000_0000_0000);
    send_double(64'h0010_0000_0000_0000);
    send_double(64'h3FF0_0000_1000_0000);
    send_double(64'h3FF0_0000_3000_0000);
    send_double(64'hBFF0_0000_1000_0001);
    send_double(64'h380F_FFFF_F000_0000);
  endtask

  // Mostly exponents near the float range, so rounding paths get exercised.
  task automatic test_random_doubles(int count);
    logic [63:0] d;
    for (int i = 0; i < count; i++) begin
      d = rand64();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: d[62:52] = 11'(1023 + $signed($urandom_range(0, 260)) - 130);
        4, 5: d[62:52] = 11'($urandom_range(850, 900));
        6: begin
          d[62:52] = 11'($urandom_range(1150, 1152));
          if ($urandom_range(0, 1)) d[28:0] = {1'b1, 28'd0};
        end
        7: d[28:0] = $urandom_range(0, 1) ? {1'b1, 28'd0} : 29'd0;
        8: d[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
        default: ;
      endcase
      send_double(d);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    test_range_edges();
    test_random_doubles(1200);
    quiet_phase = 1'b1;
    test_random_doubles(230);
    in_valid <= 1'b0;
    while (expected_floats.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Covered %0d conversions: specials, overflow edges, subnormal rounding, ties.",
             checked_count);
    if (error_count == 0) begin
      $display("PASS double_to_float_saturating");
    end else begin
      $display("FAIL double_to_float_saturating");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAIL double_to_float_saturating");
    $finish;
  end
endmodule
